// ===== rtl/core/lba_chs_pkg.sv =====
// ----------------------------------------------------------------------------
// lba_chs_pkg
// Shared types and constants for the LBA to CHS packer: register map,
// reset values, field widths and the packed result layout.
// ----------------------------------------------------------------------------
package lba_chs_pkg;

  // Register map (word index on the APB port)
  localparam logic [1:0] REG_SECTORS_PER_TRACK = 2'd0;
  localparam logic [1:0] REG_HEAD_COUNT        = 2'd1;
  localparam logic [1:0] REG_FILL_ON_OVERFLOW  = 2'd2;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int SPT_W   = 6;
  localparam int HEADS_W = 8;

  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 8'd255;

  localparam int ADDR_FIELD_W         = 32;
  localparam int ADDRESS_BITS_DEFAULT = 32;

  // Quotient bits resolved in each divider stage
  localparam int DIV_BITS_PER_STAGE = 4;

  localparam int CYL_W = 10;
  localparam logic [CYL_W-1:0] CYL_LIMIT     = 10'h3ff;
  localparam logic [CYL_W-1:0] CYL_CLIPPED   = 10'h3fe;
  localparam logic [7:0]       CYL_HIGH_MASK = 8'hc0;

  typedef struct packed {
    logic [7:0] sector_byte;
    logic [7:0] head_number;
    logic [7:0] cylinder_low;
  } chs_t;

  localparam int CHS_W = $bits(chs_t);

endpackage

// ===== rtl/core/lba_chs_div.sv =====
// ----------------------------------------------------------------------------
// lba_chs_div
// Pipelined restoring divider. Each stage resolves a few quotient bits;
// divisor and sideband travel with the partial result. One item per cycle while en is high.
// ----------------------------------------------------------------------------
module lba_chs_div #(
  parameter int DW  = 32,
  parameter int VW  = 6,
  parameter int SW  = 1,
  parameter int BPS = lba_chs_pkg::DIV_BITS_PER_STAGE
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_num,
  input  logic [VW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [VW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  localparam int NS = (DW + BPS - 1) / BPS;
  localparam int PW = NS * BPS;

  // a_* : stage inputs, q_* : stage registers
  logic          a_v    [NS];
  logic [VW-1:0] a_rem  [NS];
  logic [PW-1:0] a_work [NS];
  logic [VW-1:0] a_den  [NS];
  logic [SW-1:0] a_side [NS];

  logic          q_v    [NS];
  logic [VW-1:0] q_rem  [NS];
  logic [PW-1:0] q_work [NS];
  logic [VW-1:0] q_den  [NS];
  logic [SW-1:0] q_side [NS];

  logic [VW-1:0] rem_next  [NS];
  logic [PW-1:0] work_next [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign a_v[s]    = in_valid;
      assign a_rem[s]  = '0;
      assign a_work[s] = PW'(in_num);
      assign a_den[s]  = in_den;
      assign a_side[s] = in_side;
    end else begin : g_rest
      assign a_v[s]    = q_v[s-1];
      assign a_rem[s]  = q_rem[s-1];
      assign a_work[s] = q_work[s-1];
      assign a_den[s]  = q_den[s-1];
      assign a_side[s] = q_side[s-1];
    end

    // Shift dividend bits into the remainder, quotient bits in at the bottom
    always_comb begin
      logic [VW-1:0] r;
      logic [PW-1:0] w;
      logic [VW:0]   t;
      r = a_rem[s];
      w = a_work[s];
      t = '0;
      for (int b = 0; b < BPS; b++) begin
        t = {r, w[PW-1]};
        w = {w[PW-2:0], 1'b0};
        if (t >= {1'b0, a_den[s]}) begin
          t    = t - {1'b0, a_den[s]};
          w[0] = 1'b1;
        end
        r = t[VW-1:0];
      end
      rem_next[s]  = r;
      work_next[s] = w;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[s] <= 1'b0;
      end else if (en) begin
        q_v[s] <= a_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_rem[s]  <= rem_next[s];
        q_work[s] <= work_next[s];
        q_den[s]  <= a_den[s];
        q_side[s] <= a_side[s];
      end
    end
  end

  assign out_valid = q_v[NS-1];
  assign out_quo   = q_work[NS-1][DW-1:0];
  assign out_rem   = q_rem[NS-1];
  assign out_den   = q_den[NS-1];
  assign out_side  = q_side[NS-1];

endmodule

// ===== rtl/core/lba_chs_skid.sv =====
// ----------------------------------------------------------------------------
// lba_chs_skid
// Output register with a skid slot. Upstream ready is registered, so the
// pipeline sees a clean enable; a stalled sink parks one transaction aside.
// ----------------------------------------------------------------------------
module lba_chs_skid #(
  parameter int W = lba_chs_pkg::CHS_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         in_ready,
  output logic         out_valid,
  output logic [W-1:0] out_data,
  input  logic         out_ready
);

  logic         skid_valid;
  logic [W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        // hold the waiting transaction, park the new one
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/lba_to_chs_packer.sv =====
// ----------------------------------------------------------------------------
// lba_to_chs_packer
// Converts a logical block address to the packed cylinder/head/sector bytes
// of a partition table entry, with APB-programmed geometry.
// ----------------------------------------------------------------------------
// One conversion enters every cycle while s_axis_tready is high. The path from
// input transaction to result runs through a pipelined divider by sectors
// per track, a second by head count, each resolving four quotient bits per
// stage, then a packing stage and the output register. A skid slot behind
// the output register keeps s_axis_tready registered; it drops only while a
// result is parked behind a stalled sink.
// Geometry registers are to be written only while no conversion is in flight.
module lba_to_chs_packer #(
  parameter int ADDRESS_BITS = lba_chs_pkg::ADDRESS_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lba_chs_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lba_chs_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lba_chs_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                pready,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lba_chs_pkg::ADDR_FIELD_W-1:0] s_axis_tdata,  // [31:0] block_address
  input  logic                                s_axis_tuser,  // [0] clip_flag
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] cylinder_low, [15:8] head_number, [23:16] sector_byte
  output logic [lba_chs_pkg::CHS_W-1:0]       m_axis_tdata
);

  localparam int EW = (ADDRESS_BITS < lba_chs_pkg::ADDR_FIELD_W) ?
                      ADDRESS_BITS : lba_chs_pkg::ADDR_FIELD_W;
  localparam int SPT_W   = lba_chs_pkg::SPT_W;
  localparam int HEADS_W = lba_chs_pkg::HEADS_W;
  localparam int SIDE2_W = 1 + 2 * SPT_W;

  // Configuration registers
  logic [SPT_W-1:0]   sectors_per_track;
  logic [HEADS_W-1:0] head_count;
  logic               fill_on_overflow;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= lba_chs_pkg::SPT_RESET;
      head_count        <= lba_chs_pkg::HEADS_RESET;
      fill_on_overflow  <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        lba_chs_pkg::REG_SECTORS_PER_TRACK: sectors_per_track <= pwdata[SPT_W-1:0];
        lba_chs_pkg::REG_HEAD_COUNT:        head_count        <= pwdata[HEADS_W-1:0];
        lba_chs_pkg::REG_FILL_ON_OVERFLOW:  fill_on_overflow  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lba_chs_pkg::REG_SECTORS_PER_TRACK:
        prdata = lba_chs_pkg::APB_DATA_W'(sectors_per_track);
      lba_chs_pkg::REG_HEAD_COUNT:
        prdata = lba_chs_pkg::APB_DATA_W'(head_count);
      lba_chs_pkg::REG_FILL_ON_OVERFLOW:
        prdata = lba_chs_pkg::APB_DATA_W'(fill_on_overflow);
      default:
        prdata = '0;
    endcase
  end

  // A zero divisor behaves as one
  logic [SPT_W-1:0]   spt_eff;
  logic [HEADS_W-1:0] heads_eff;

  assign spt_eff   = (sectors_per_track == '0) ? SPT_W'(1) : sectors_per_track;
  assign heads_eff = (head_count == '0) ? HEADS_W'(1) : head_count;

  logic en;
  logic in_valid;

  assign en       = s_axis_tready;
  assign in_valid = s_axis_tvalid;

  // Track = address / sectors per track
  logic             d1_valid;
  logic [EW-1:0]    d1_quo;
  logic [SPT_W-1:0] d1_rem;
  logic [SPT_W-1:0] d1_den;
  logic             d1_clip;

  lba_chs_div #(
    .DW (EW),
    .VW (SPT_W),
    .SW (1)
  ) u_div_track (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_num   (s_axis_tdata[EW-1:0]),
    .in_den   (spt_eff),
    .in_side  (s_axis_tuser),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem),
    .out_den  (d1_den),
    .out_side (d1_clip)
  );

  // Cylinder = track / heads, head = track % heads
  logic               d2_valid;
  logic [EW-1:0]      d2_quo;
  logic [HEADS_W-1:0] d2_rem;
  logic [HEADS_W-1:0] d2_den;
  logic [SIDE2_W-1:0] d2_side;
  logic               d2_clip;
  logic [SPT_W-1:0]   d2_sec_rem;
  logic [SPT_W-1:0]   d2_spt;

  lba_chs_div #(
    .DW (EW),
    .VW (HEADS_W),
    .SW (SIDE2_W)
  ) u_div_cyl (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_valid),
    .in_num   (d1_quo),
    .in_den   (heads_eff),
    .in_side  ({d1_clip, d1_rem, d1_den}),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_rem  (d2_rem),
    .out_den  (d2_den),
    .out_side (d2_side)
  );

  assign {d2_clip, d2_sec_rem, d2_spt} = d2_side;

  // Saturate and pack
  logic                          over;
  logic [lba_chs_pkg::CYL_W-1:0] cyl;
  logic [SPT_W-1:0]              sector;
  logic [HEADS_W-1:0]            head;
  lba_chs_pkg::chs_t             pack_next;

  always_comb begin
    over   = d2_quo > EW'(lba_chs_pkg::CYL_LIMIT);
    cyl    = d2_quo[lba_chs_pkg::CYL_W-1:0];
    sector = d2_sec_rem + SPT_W'(1);
    head   = d2_rem;
    if (over) begin
      cyl = d2_clip ? lba_chs_pkg::CYL_CLIPPED : lba_chs_pkg::CYL_LIMIT;
      if (fill_on_overflow) begin
        sector = d2_spt;
        head   = d2_den - HEADS_W'(1);
      end
    end
    pack_next.cylinder_low = cyl[7:0];
    pack_next.head_number  = head;
    pack_next.sector_byte  = (8'(sector) & ~lba_chs_pkg::CYL_HIGH_MASK)
                           | ({cyl[9:8], 6'b0} & lba_chs_pkg::CYL_HIGH_MASK);
  end

  logic              pack_valid;
  lba_chs_pkg::chs_t pack_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_valid <= 1'b0;
    end else if (en) begin
      pack_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pack_data <= pack_next;
    end
  end

  lba_chs_skid #(
    .W (lba_chs_pkg::CHS_W)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pack_valid),
    .in_data  (pack_data),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata),
    .out_ready(m_axis_tready)
  );

  // Sector field of every result is one-based
  a_sector_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[21:16] != 6'd0)
    else $error("result carries sector zero");

  // The pipeline only stops behind a stalled sink
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // The skid slot fills only from a finished conversion
  a_skid_source: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(pack_valid))
    else $error("skid slot filled without a packed result");

endmodule
